>>> rtl/two_level_page_table_engine_top_assert.svh
// assertion macros for the page table engine
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH
// implication checked every cycle outside reset
`define TLPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TLPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// types and constants shared by the page table engine
// ----------------------------------------------------------------------------
package tlpt_pkg;
  localparam int unsigned DirEntries   = 1024;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned PoolTables   = 256;
  localparam int unsigned DirIdxW      = 10;
  localparam int unsigned TblIdxW      = 10;
  localparam int unsigned PoolIdxW     = 8;
  localparam int unsigned CountW       = 9;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned WmapWords    = PoolTables * TableEntries / 32;
  localparam int unsigned WmapIdxW     = 13;

  localparam logic [1:0] CmdMap       = 2'd0;
  localparam logic [1:0] CmdUnmap     = 2'd1;
  localparam logic [1:0] CmdTranslate = 2'd2;
  localparam logic [1:0] CmdReserved  = 2'd3;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StExhausted = 2'd1;
  localparam logic [1:0] StNotMapped = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;
  } req_t;

  typedef struct packed {
    logic [31:0] translated_addr;
    logic [1:0]  status;
    logic [8:0]  tables_in_use;
  } rsp_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic                op_write;   // store an entry
    logic                op_read;    // translate
    logic                nop;        // no table access
    logic [1:0]          status;
    logic [PoolIdxW-1:0] table_no;
    logic [TblIdxW-1:0]  tbl_idx;
    logic [11:0]         offset;
    logic [31:0]         pte;
    logic                fresh;      // table newly allocated
    logic [CountW-1:0]   count;
  } op_t;
endpackage

>>> rtl/two_level_page_table_engine_top.sv
// an accepted input beat passes the directory read, op register, queue, table read
// and result register; front and back each take a new one only once their read is done
// reset: asynchronous, active low; table count clears at once, then passes clear
// the directory and the table written map
// input beats wait for the directory pass, results for the written map pass
// ----------------------------------------------------------------------------
// two_level_page_table_engine_top
// two-level page table with map, unmap and translate
// ----------------------------------------------------------------------------
module two_level_page_table_engine_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlpt_pkg::req_t in_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output tlpt_pkg::rsp_t out_data_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);
  import tlpt_pkg::*;

  op_t f_op, q_op;
  logic f_v, f_r, q_v, q_r;

  tlpt_front u_front (
    .clk_i, .rst_ni, .req_i(in_data_i), .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o), .op_o(f_op), .op_valid_o(f_v), .op_ready_i(f_r)
  );

  tlpt_queue u_queue (
    .clk_i, .rst_ni, .in_i(f_op), .in_valid_i(f_v), .in_ready_o(f_r),
    .out_o(q_op), .out_valid_o(q_v), .out_ready_i(q_r)
  );

  tlpt_back u_back (
    .clk_i, .rst_ni, .op_i(q_op), .op_valid_i(q_v), .op_ready_o(q_r),
    .rsp_o(out_data_o), .rsp_valid_o(out_valid_o), .rsp_ready_i(out_ready_i)
  );
endmodule

>>> rtl/tlpt_front.sv
// ----------------------------------------------------------------------------
// tlpt_front
// directory lookup, table allocation and command classification
// ----------------------------------------------------------------------------
module tlpt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlpt_pkg::req_t req_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output tlpt_pkg::op_t  op_o,
  output logic           op_valid_o,
  input  logic           op_ready_i
);
  import tlpt_pkg::*;

  // directory memory, present bit above the table number
  logic [PoolIdxW:0] dir_mem [DirEntries];
  logic [DirIdxW-1:0] clr_idx_q;
  logic clr_q;
  logic [CountW-1:0] count_q;
  logic [PoolIdxW:0] dent_q;
  logic busy_q, rd_q;
  req_t req_q;
  op_t  op_q;
  logic opv_q;

  assign req_ready_o = !clr_q && !busy_q && (!opv_q || op_ready_i);
  assign op_o = op_q;
  assign op_valid_o = opv_q;

  logic [DirIdxW-1:0] didx;
  logic dpres, alloc, full;
  assign didx  = req_q.virt_addr[31:22];
  assign dpres = dent_q[PoolIdxW];
  assign full  = (count_q >= CountW'(PoolTables));
  assign alloc = (req_q.command == CmdMap) && !dpres && !full;

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      dent_q <= dir_mem[req_i.virt_addr[31:22]];
    end
    if (clr_q) begin
      dir_mem[clr_idx_q] <= '0;
    end else if (rd_q && alloc) begin
      dir_mem[didx] <= {1'b1, count_q[PoolIdxW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
  end

  op_t op_d;
  always_comb begin
    op_d = '0;
    op_d.tbl_idx  = req_q.virt_addr[21:12];
    op_d.offset   = req_q.virt_addr[11:0];
    op_d.table_no = alloc ? count_q[PoolIdxW-1:0] : dent_q[PoolIdxW-1:0];
    op_d.fresh    = alloc;
    op_d.count    = alloc ? count_q + 1'b1 : count_q;
    op_d.status   = StOk;
    op_d.nop      = 1'b1;
    case (req_q.command)
      CmdMap: begin
        if (dpres || alloc) begin
          op_d.op_write = 1'b1;
          op_d.nop = 1'b0;
          op_d.pte = {req_q.phys_addr[31:12], req_q.page_flags[11:1], 1'b1};
        end else begin
          op_d.status = StExhausted;
        end
      end
      CmdUnmap: begin
        if (dpres) begin
          op_d.op_write = 1'b1;
          op_d.nop = 1'b0;
        end
      end
      CmdTranslate: begin
        if (dpres) begin
          op_d.op_read = 1'b1;
          op_d.nop = 1'b0;
        end else begin
          op_d.status = StNotMapped;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rd_q <= 1'b0;
      opv_q <= 1'b0;
      count_q <= '0;
      clr_q <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == DirIdxW'(DirEntries - 1)) clr_q <= 1'b0;
      end
      if (opv_q && op_ready_i) opv_q <= 1'b0;
      rd_q <= 1'b0;
      if (req_valid_i && req_ready_o) begin
        busy_q <= 1'b1;
        rd_q <= 1'b1;
      end
      if (rd_q) begin
        busy_q <= 1'b0;
        opv_q <= 1'b1;
        if (alloc) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_q) op_q <= op_d;
  end

  `include "two_level_page_table_engine_top_assert.svh"
  `TLPT_ASSERT_IMP(a_count_max, 1'b1, count_q <= CountW'(PoolTables))
  `TLPT_ASSERT_IMP(a_no_accept_busy, busy_q, !req_ready_o)
  `TLPT_ASSERT_NXT(a_alloc_count, rd_q && alloc, count_q == $past(count_q) + 1'b1)
endmodule

>>> rtl/tlpt_queue.sv
// ----------------------------------------------------------------------------
// tlpt_queue
// short queue between front and back
// ----------------------------------------------------------------------------
module tlpt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tlpt_pkg::op_t in_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output tlpt_pkg::op_t out_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);
  import tlpt_pkg::*;

  op_t mem_q [QueueDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != 2'(QueueDepth);
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/tlpt_back.sv
// ----------------------------------------------------------------------------
// tlpt_back
// table pool access with per-entry written map and result register
// ----------------------------------------------------------------------------
module tlpt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlpt_pkg::op_t  op_i,
  input  logic           op_valid_i,
  output logic           op_ready_o,
  output tlpt_pkg::rsp_t rsp_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i
);
  import tlpt_pkg::*;

  localparam int unsigned SlotW = PoolIdxW + TblIdxW;

  logic [31:0] pool_mem [PoolTables*TableEntries];
  // written map: one bit per table entry, 32 entries a word, cleared after reset
  logic [31:0] wmap_mem [WmapWords];
  logic clr_q;
  logic [WmapIdxW-1:0] clr_idx_q;

  logic busy_q, rsp_v_q;
  op_t  cur_q;
  logic [31:0] rd_q;
  logic [31:0] wm_q;
  logic [31:0] wm_d;
  rsp_t rsp_q;
  logic [SlotW-1:0] slot;
  logic [WmapIdxW-1:0] widx;
  logic [WmapIdxW-1:0] wr_widx;

  assign slot = {op_i.table_no, op_i.tbl_idx};
  assign widx = {op_i.table_no, op_i.tbl_idx[TblIdxW-1:5]};
  assign wr_widx = {cur_q.table_no, cur_q.tbl_idx[TblIdxW-1:5]};
  assign op_ready_o = !clr_q && !busy_q && (!rsp_v_q || rsp_ready_i);
  assign rsp_o = rsp_q;
  assign rsp_valid_o = rsp_v_q;

  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_ready_o) begin
      if (op_i.op_write) begin
        pool_mem[slot] <= op_i.pte;
      end
      rd_q <= pool_mem[slot];
      cur_q <= op_i;
    end
  end

  always_comb begin
    wm_d = wm_q;
    wm_d[cur_q.tbl_idx[4:0]] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i && op_ready_o) wm_q <= wmap_mem[widx];
    if (clr_q) begin
      wmap_mem[clr_idx_q] <= '0;
    end else if (busy_q && cur_q.op_write) begin
      wmap_mem[wr_widx] <= wm_d;
    end
  end

  logic hit;
  assign hit = wm_q[cur_q.tbl_idx[4:0]] && rd_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rsp_v_q <= 1'b0;
      clr_q <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == WmapIdxW'(WmapWords - 1)) clr_q <= 1'b0;
      end
      if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
      if (op_valid_i && op_ready_o) begin
        busy_q <= 1'b1;
      end
      if (busy_q) begin
        busy_q <= 1'b0;
        rsp_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rsp_q.tables_in_use <= cur_q.count;
      rsp_q.status <= cur_q.status;
      rsp_q.translated_addr <= '0;
      if (cur_q.op_read) begin
        if (hit) rsp_q.translated_addr <= {rd_q[31:12], cur_q.offset};
        else rsp_q.status <= StNotMapped;
      end
    end
  end

  `include "two_level_page_table_engine_top_assert.svh"
  `TLPT_ASSERT_IMP(a_one_kind, op_valid_i, !(op_i.op_write && op_i.op_read))
  `TLPT_ASSERT_NXT(a_busy_rsp, busy_q, rsp_v_q)
  `TLPT_ASSERT_IMP(a_nop_status, op_valid_i && op_i.nop, !op_i.fresh)
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// page table engine check: map, unmap, translate and reserved beats are driven with
// random gaps and stalls, each result is compared with a behavioural copy of
// the directory, the table pool and the allocation count
// ----------------------------------------------------------------------------
module tb_top;
  import tlpt_pkg::*;

  localparam int unsigned WatchdogLimit = 40000;
  localparam int unsigned HoldCycles    = 300;

  logic clk_i;
  logic rst_ni;
  req_t in_data_i;
  logic in_valid_i;
  logic in_ready_o;
  rsp_t out_data_o;
  logic out_valid_o;
  logic out_ready_i;

  two_level_page_table_engine_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  req_t        pending_req[$];
  rsp_t        expected_rsp[$];
  logic [31:0] mapped_virt[$];
  bit          dir_present[DirEntries];
  int unsigned dir_table[DirEntries];
  logic [31:0] pte_store[int unsigned];
  int unsigned tables_used;
  int unsigned errors;
  int unsigned results_seen;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned hold_left;
  bit          hold_done;
  bit          send_burst;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic rsp_t walk_table(req_t r);
    rsp_t        rsp;
    int unsigned didx;
    int unsigned key;
    logic [31:0] pte;
    didx = r.virt_addr[31:22];
    rsp = '0;
    rsp.status = StOk;
    key = dir_table[didx] * TableEntries + r.virt_addr[21:12];
    case (r.command)
      CmdMap: begin
        if (!dir_present[didx]) begin
          if (tables_used >= PoolTables) begin
            rsp.status = StExhausted;
          end else begin
            dir_table[didx] = tables_used;
            dir_present[didx] = 1'b1;
            tables_used++;
            key = dir_table[didx] * TableEntries + r.virt_addr[21:12];
          end
        end
        if (dir_present[didx])
          pte_store[key] = {r.phys_addr[31:12], r.page_flags | 12'h001};
      end
      CmdUnmap: begin
        if (dir_present[didx]) pte_store[key] = '0;
      end
      CmdTranslate: begin
        pte = (dir_present[didx] && pte_store.exists(key)) ? pte_store[key] : '0;
        if (dir_present[didx] && pte[0]) rsp.translated_addr = {pte[31:12], r.virt_addr[11:0]};
        else rsp.status = StNotMapped;
      end
      default: ;
    endcase
    rsp.tables_in_use = tables_used[8:0];
    return rsp;
  endfunction

  task automatic add_req(logic [1:0] cmd, logic [31:0] va, logic [31:0] pa, logic [11:0] fl);
    req_t r;
    r.command = cmd;
    r.virt_addr = va;
    r.phys_addr = pa;
    r.page_flags = fl;
    pending_req.push_back(r);
    if (cmd == CmdMap) mapped_virt.push_back(va);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      send_gap <= 0;
      send_burst <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) expected_rsp.push_back(walk_table(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_req.size() != 0) begin
          in_data_i <= pending_req.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 60) == 0) send_burst <= ~send_burst;
          send_gap <= send_burst ? 0 : $urandom_range(0, 15);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_data_o);
          errors++;
        end else begin
          exp_rsp = expected_rsp.pop_front();
          if (out_data_o.translated_addr !== exp_rsp.translated_addr) begin
            $display("%0t: translated_addr expected %h actual %h", $time,
                     exp_rsp.translated_addr, out_data_o.translated_addr);
            errors++;
          end
          if (out_data_o.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_rsp.status, out_data_o.status);
            errors++;
          end
          if (out_data_o.tables_in_use !== exp_rsp.tables_in_use) begin
            $display("%0t: tables_in_use expected %0d actual %0d", $time,
                     exp_rsp.tables_in_use, out_data_o.tables_in_use);
            errors++;
          end
        end
        recv_stall <= send_burst ? 0 : $urandom_range(0, 15);
      end
      // long hold-off so the engine fills up and back-pressures its input
      if (!hold_done && results_seen >= 400) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i) begin
        out_ready_i <= send_burst;
      end else if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0]  cmd;
    logic [31:0] va;
    int unsigned sel;
    errors = 0;
    results_seen = 0;
    tables_used = 0;
    quiet_cycles = 0;
    foreach (dir_present[i]) begin
      dir_present[i] = 1'b0;
      dir_table[i] = 0;
    end
    rst_ni = 1'b0;

    // directed beats
    add_req(CmdTranslate, 32'h0000_0000, 32'h0, 12'h000);
    add_req(CmdUnmap,     32'h0000_0000, 32'h0, 12'h000);
    add_req(CmdMap,       32'h0000_0000, 32'h0000_0000, 12'h000);
    add_req(CmdTranslate, 32'h0000_0FFF, 32'h0, 12'h000);
    add_req(CmdMap,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    add_req(CmdTranslate, 32'hFFFF_F000, 32'h0, 12'h000);
    add_req(CmdTranslate, 32'hFFFF_FFFF, 32'h0, 12'h000);
    add_req(CmdTranslate, 32'hFFC0_0000, 32'h0, 12'h000);
    add_req(CmdMap,       32'hFFC0_0123, 32'h1234_5FFF, 12'hFFE);
    add_req(CmdTranslate, 32'hFFC0_0ABC, 32'h0, 12'h000);
    add_req(CmdUnmap,     32'hFFFF_F000, 32'h0, 12'h000);
    add_req(CmdTranslate, 32'hFFFF_F001, 32'h0, 12'h000);
    add_req(CmdUnmap,     32'h8000_0000, 32'h0, 12'h000);
    add_req(CmdReserved,  32'h8000_0000, 32'hFFFF_FFFF, 12'hFFF);
    add_req(CmdMap,       32'h8000_0000, 32'hAAAA_A000, 12'h555);
    add_req(CmdMap,       32'h8000_0000, 32'h5555_5FFF, 12'hAAA);
    add_req(CmdTranslate, 32'h8000_0555, 32'h0, 12'h000);
    add_req(CmdReserved,  32'hFFFF_FFFF, 32'h0, 12'h000);

    // random beats, mostly well-formed walks over a working set
    for (int unsigned n = 0; n < 1600; n++) begin
      sel = $urandom_range(0, 99);
      va = $urandom();
      if (n >= 700 && n < 1000) begin
        cmd = CmdMap;
        va[31:22] = n[9:0];
      end else begin
        if (sel < 40) cmd = CmdMap;
        else if (sel < 55) cmd = CmdUnmap;
        else if (sel < 95) cmd = CmdTranslate;
        else cmd = CmdReserved;
        if (cmd != CmdMap && mapped_virt.size() != 0 && $urandom_range(0, 9) < 7) begin
          va[31:12] = mapped_virt[$urandom_range(0, mapped_virt.size() - 1)][31:12];
        end else if ($urandom_range(0, 1) == 0) begin
          va[31:22] = $urandom_range(0, 7);
        end
      end
      add_req(cmd, va, $urandom(), $urandom_range(0, 4095));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_req.size() == 0 && !in_valid_i && expected_rsp.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/tlpt_pkg.sv
rtl/tlpt_front.sv
rtl/tlpt_queue.sv
rtl/tlpt_back.sv
rtl/two_level_page_table_engine_top.sv
tb/sv/tb_top.sv
